@@ rtl/core/rcnt_pkg.sv @@
// ----------------------------------------------------------------------------
// rcnt_pkg
// Shared codes, mode word bit positions and the command type passed from the
// decode front end to the timer back end.
// ----------------------------------------------------------------------------
package rcnt_pkg;

    localparam int DATA_W = 16;
    localparam int MODE_W = 13;

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register offsets on the bus
    localparam logic [3:0] OFF_COUNT  = 4'h0;
    localparam logic [3:0] OFF_MODE   = 4'h4;
    localparam logic [3:0] OFF_TARGET = 4'h8;

    // decoded register select
    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;
    localparam logic [1:0] REG_NONE   = 2'd3;

    // sync modes that pause the divided timer
    localparam logic [1:0] SYNC_PAUSE_A = 2'd0;
    localparam logic [1:0] SYNC_PAUSE_B = 2'd3;

    // mode word bits
    localparam int MB_SYNC_EN  = 0;
    localparam int MB_SYNC_LO  = 1;
    localparam int MB_SYNC_HI  = 2;
    localparam int MB_RST_TGT  = 3;
    localparam int MB_IRQ_TGT  = 4;
    localparam int MB_IRQ_MAX  = 5;
    localparam int MB_REPEAT   = 6;
    localparam int MB_TOGGLE   = 7;
    localparam int MB_CLK_HI   = 9;
    localparam int MB_IRQ_NOT  = 10;
    localparam int MB_HIT_TGT  = 11;
    localparam int MB_HIT_MAX  = 12;

    // the timer whose clock can be divided, and the divide shift
    localparam int DIV_TIMER = 2;
    localparam int DIV_SHIFT = 3;

    localparam int IRQ_W = 3;

    localparam logic [DATA_W-1:0] READ_ERR_VALUE = 16'hFFFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [1:0]        op;
        logic              err;
        logic [1:0]        timer;
        logic [1:0]        regsel;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

@@ rtl/core/rcnt_front.sv @@
// ----------------------------------------------------------------------------
// rcnt_front
// Decodes an incoming beat into a command: checks the timer and register
// offset, picks the data word and flags invalid bus accesses.
// ----------------------------------------------------------------------------
module rcnt_front #(
    parameter int NUM_TIMERS = 3
) (
    input  logic [1:0]                    s_opcode,
    input  logic [1:0]                    s_timer_select,
    input  logic [3:0]                    s_reg_offset,
    input  logic [rcnt_pkg::DATA_W-1:0]   s_write_data,
    input  logic [rcnt_pkg::DATA_W-1:0]   s_tick_cycles,
    output rcnt_pkg::cmd_t                cmd
);
    import rcnt_pkg::*;

    logic timer_ok;
    logic [1:0] regsel;
    logic is_bus;

    assign timer_ok = (s_timer_select < 2'(NUM_TIMERS));
    assign is_bus   = (s_opcode == OP_READ) || (s_opcode == OP_WRITE);

    always_comb begin
        unique case (s_reg_offset)
            OFF_COUNT:  regsel = REG_COUNT;
            OFF_MODE:   regsel = REG_MODE;
            OFF_TARGET: regsel = REG_TARGET;
            default:    regsel = REG_NONE;
        endcase
    end

    always_comb begin
        cmd.op     = s_opcode;
        cmd.err    = is_bus && !(timer_ok && (regsel != REG_NONE));
        cmd.timer  = s_timer_select;
        cmd.regsel = regsel;
        cmd.data   = (s_opcode == OP_TICK) ? s_tick_cycles : s_write_data;
    end

endmodule

@@ rtl/core/rcnt_queue.sv @@
// ----------------------------------------------------------------------------
// rcnt_queue
// Two-entry command queue between the decode front end and the timer back
// end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module rcnt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rcnt_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output rcnt_pkg::cmd_t  head_cmd
);
    import rcnt_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/rcnt_back.sv @@
// ----------------------------------------------------------------------------
// rcnt_back
// Timer back end: holds the counter, mode and target registers of every
// timer, carries out ticks and bus accesses, and holds the result beat.
// ----------------------------------------------------------------------------
module rcnt_back #(
    parameter int NUM_TIMERS = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  rcnt_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rcnt_pkg::DATA_W-1:0]   m_read_data,
    output logic [rcnt_pkg::IRQ_W-1:0]    m_irq_fired,
    output logic                          m_access_error
);
    import rcnt_pkg::*;

    logic [DATA_W-1:0] count_reg   [NUM_TIMERS];
    logic [DATA_W-1:0] count_next  [NUM_TIMERS];
    logic [MODE_W-1:0] mode_reg    [NUM_TIMERS];
    logic [MODE_W-1:0] mode_next   [NUM_TIMERS];
    logic [DATA_W-1:0] target_reg  [NUM_TIMERS];
    logic [DATA_W-1:0] target_next [NUM_TIMERS];
    logic              paused_reg  [NUM_TIMERS];
    logic              paused_next [NUM_TIMERS];
    logic              seen_reg    [NUM_TIMERS];
    logic              seen_next   [NUM_TIMERS];
    logic              fire        [NUM_TIMERS];

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic [IRQ_W-1:0]  irq_reg, irq_next;
    logic              err_reg, err_next;
    logic [DATA_W-1:0] rd_val;

    assign cmd_pop = cmd_valid && (!m_valid_reg || m_ready);

    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
        logic              sel;
        logic [DATA_W-1:0] inc;
        logic [DATA_W:0]   sum;
        logic              hit_tgt;
        logic              hit_max;
        logic              could;
        logic [MODE_W-1:0] m_flag;
        logic [MODE_W-1:0] m_irq;
        logic [MODE_W-1:0] m_wr;
        logic              pause_wr;

        assign sel = (cmd.timer == 2'(i));

        always_comb begin
            if ((i == DIV_TIMER) && mode_reg[i][MB_CLK_HI]) begin
                inc = cmd.data >> DIV_SHIFT;
            end else begin
                inc = cmd.data;
            end
            sum     = {1'b0, count_reg[i]} + {1'b0, inc};
            hit_tgt = (sum > {1'b0, target_reg[i]});
            hit_max = sum[DATA_W] && !(hit_tgt && mode_reg[i][MB_RST_TGT]);
            could   = (hit_tgt && mode_reg[i][MB_IRQ_TGT])
                    || (hit_max && mode_reg[i][MB_IRQ_MAX]);
            m_flag  = mode_reg[i];
            if (hit_tgt) begin
                m_flag[MB_HIT_TGT] = 1'b1;
            end
            if (hit_max) begin
                m_flag[MB_HIT_MAX] = 1'b1;
            end
            m_irq = m_flag;
            m_irq[MB_IRQ_NOT] = m_flag[MB_TOGGLE] ? ~m_flag[MB_IRQ_NOT] : 1'b0;
            m_wr = cmd.data[MODE_W-1:0];
            m_wr[MB_IRQ_NOT] = 1'b1;
            pause_wr = (i == DIV_TIMER) && m_wr[MB_SYNC_EN]
                && ((m_wr[MB_SYNC_HI:MB_SYNC_LO] == SYNC_PAUSE_A)
                 || (m_wr[MB_SYNC_HI:MB_SYNC_LO] == SYNC_PAUSE_B));
        end

        always_comb begin
            count_next[i]  = count_reg[i];
            mode_next[i]   = mode_reg[i];
            target_next[i] = target_reg[i];
            paused_next[i] = paused_reg[i];
            seen_next[i]   = seen_reg[i];
            fire[i]        = 1'b0;
            if (cmd_pop) begin
                unique case (cmd.op)
                    OP_TICK: begin
                        if (!paused_reg[i]) begin
                            if ((hit_tgt && mode_reg[i][MB_RST_TGT]) ||
                                (hit_max && !mode_reg[i][MB_RST_TGT])) begin
                                count_next[i] = '0;
                            end else begin
                                count_next[i] = sum[DATA_W-1:0];
                            end
                            if (!could) begin
                                mode_next[i] = m_flag;
                            end else if (!m_irq[MB_REPEAT] && seen_reg[i]) begin
                                mode_next[i] = m_irq;
                            end else begin
                                if (!m_irq[MB_IRQ_NOT]) begin
                                    fire[i]      = 1'b1;
                                    seen_next[i] = 1'b1;
                                end
                                mode_next[i] = m_irq;
                                mode_next[i][MB_IRQ_NOT] = 1'b1;
                            end
                        end
                    end
                    OP_READ: begin
                        if (!cmd.err && sel && (cmd.regsel == REG_MODE)) begin
                            mode_next[i][MB_HIT_TGT] = 1'b0;
                            mode_next[i][MB_HIT_MAX] = 1'b0;
                            seen_next[i]  = 1'b0;
                            count_next[i] = '0;
                        end
                    end
                    OP_WRITE: begin
                        if (!cmd.err && sel) begin
                            unique case (cmd.regsel)
                                REG_COUNT: count_next[i] = cmd.data;
                                REG_MODE: begin
                                    mode_next[i]   = m_wr;
                                    paused_next[i] = pause_wr;
                                    seen_next[i]   = 1'b0;
                                    count_next[i]  = '0;
                                end
                                REG_TARGET: target_next[i] = cmd.data;
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                count_reg[i]  <= '0;
                mode_reg[i]   <= '0;
                target_reg[i] <= '0;
                paused_reg[i] <= 1'b0;
                seen_reg[i]   <= 1'b0;
            end else begin
                count_reg[i]  <= count_next[i];
                mode_reg[i]   <= mode_next[i];
                target_reg[i] <= target_next[i];
                paused_reg[i] <= paused_next[i];
                seen_reg[i]   <= seen_next[i];
            end
        end
    end

    always_comb begin
        rd_val = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (cmd.timer == 2'(i)) begin
                unique case (cmd.regsel)
                    REG_COUNT:  rd_val = count_reg[i];
                    REG_MODE:   rd_val = DATA_W'(mode_reg[i]);
                    REG_TARGET: rd_val = target_reg[i];
                    default:    rd_val = '0;
                endcase
            end
        end
    end

    always_comb begin
        irq_next       = irq_reg;
        read_data_next = read_data_reg;
        err_next       = err_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (cmd_pop) begin
            m_valid_next   = 1'b1;
            irq_next       = '0;
            read_data_next = '0;
            err_next       = cmd.err;
            unique case (cmd.op)
                OP_TICK: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        irq_next[i] = fire[i];
                    end
                end
                OP_READ: read_data_next = cmd.err ? READ_ERR_VALUE : rd_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        read_data_reg <= read_data_next;
        irq_reg       <= irq_next;
        err_reg       <= err_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = read_data_reg;
    assign m_irq_fired    = irq_reg;
    assign m_access_error = err_reg;

endmodule

@@ rtl/core/three_channel_root_counter_timer_unit.sv @@
// ----------------------------------------------------------------------------
// three_channel_root_counter_timer_unit
// Three 16-bit root counters with mode and target registers, driven by
// register read/write beats and tick beats; one result beat per input beat.
// ----------------------------------------------------------------------------
// Every accepted beat (tick, register read or register write) yields exactly
// one result beat, in order. While m_ready stays high the block sustains one
// beat per cycle: a beat is decoded on entry into a two-entry queue, and the
// timer back end takes one command per cycle whenever its result register is
// empty or being drained, updating all timers in parallel. A command is held
// in the queue, then its result in the result register. s_ready drops only
// while the queue holds two commands, which happens when m_ready is held low.
module three_channel_root_counter_timer_unit #(
    parameter int NUM_TIMERS = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [1:0]                    s_timer_select,
    input  logic [3:0]                    s_reg_offset,
    input  logic [rcnt_pkg::DATA_W-1:0]   s_write_data,
    input  logic [rcnt_pkg::DATA_W-1:0]   s_tick_cycles,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rcnt_pkg::DATA_W-1:0]   m_read_data,
    output logic [rcnt_pkg::IRQ_W-1:0]    m_irq_fired,
    output logic                          m_access_error
);
    import rcnt_pkg::*;

    cmd_t in_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_not_empty;
    logic q_pop;

    assign s_ready = !q_full;

    rcnt_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .s_opcode       (s_opcode),
        .s_timer_select (s_timer_select),
        .s_reg_offset   (s_reg_offset),
        .s_write_data   (s_write_data),
        .s_tick_cycles  (s_tick_cycles),
        .cmd            (in_cmd)
    );

    rcnt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_cmd  (in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    rcnt_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (q_not_empty),
        .cmd            (head_cmd),
        .cmd_pop        (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_irq_fired    (m_irq_fired),
        .m_access_error (m_access_error)
    );

endmodule

@@ rtl/core/rcnt_checker.sv @@
// ----------------------------------------------------------------------------
// rcnt_checker
// Port-level checks on the root counter unit, bound to its top level.
// ----------------------------------------------------------------------------
module rcnt_checker #(
    parameter int NUM_TIMERS = 3
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rcnt_pkg::DATA_W-1:0]   m_read_data,
    input logic [rcnt_pkg::IRQ_W-1:0]    m_irq_fired,
    input logic                          m_access_error
);
    import rcnt_pkg::*;

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_irq_fired) && $stable(m_access_error))
        else $error("result beat changed while stalled");

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat out of reset");

    // a bus error never carries interrupts, and reads back all ones or zero
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_access_error |-> m_irq_fired == '0
            && (m_read_data == READ_ERR_VALUE || m_read_data == '0))
        else $error("bad error beat");

    // interrupts and read data never share a beat
    a_irq_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_irq_fired != '0) |-> m_read_data == '0)
        else $error("irq beat with read data");

    // no interrupt from a timer that is not built
    a_irq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_irq_fired >> NUM_TIMERS) == '0)
        else $error("irq from missing timer");

endmodule

bind three_channel_root_counter_timer_unit rcnt_checker #(
    .NUM_TIMERS (NUM_TIMERS)
) u_rcnt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_data    (m_read_data),
    .m_irq_fired    (m_irq_fired),
    .m_access_error (m_access_error)
);
